FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. All of them sample on clk_i and are
// disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_PROP(lbl, !(expr), msg)

`else

`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

FILE: rtl/arc_pkg.sv
package arc_pkg;

  localparam int CACHE_ENTRIES = 32;
  localparam int SLOT_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_OUR_IP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUR_MAC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_IP = 2'd2;

  localparam logic [1:0] KIND_ARP     = 2'd0;
  localparam logic [1:0] KIND_RESOLVE = 2'd1;
  localparam logic [1:0] KIND_ADD     = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_BAD   = 2'd2;

  localparam logic [10:0] MIN_HDR_BYTES = 11'd28;
  localparam logic [15:0] HW_ETHERNET   = 16'h0001;
  localparam logic [15:0] PROTO_IPV4    = 16'h0800;
  localparam logic [7:0]  MAC_BYTES     = 8'd6;
  localparam logic [7:0]  IP_BYTES      = 8'd4;
  localparam logic [15:0] OP_REQUEST    = 16'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] frame_length;
    logic [15:0] hw_type;
    logic [15:0] ptype;
    logic [7:0]  hw_len;
    logic [7:0]  plen;
    logic [15:0] operation;
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [31:0] query_ip;
  } arc_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        reply_needed;
    logic [47:0] peer_mac;
    logic [31:0] peer_ip;
    logic        lookup_hit;
    logic        request_needed;
    logic        dad_conflict;
  } arc_result_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic write;
    logic finish;
  } arc_cmd_t;

  typedef struct packed {
    logic need_search;
    logic need_write;
    logic found;
    logic scan_miss;
  } arc_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_FINISH,
    ST_RESP
  } arc_state_e;

endpackage

FILE: rtl/arc_in_if.sv
interface arc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [10:0] frame_length;
  logic [15:0] hw_type;
  logic [15:0] ptype;
  logic [7:0]  hw_len;
  logic [7:0]  plen;
  logic [15:0] operation;
  logic [47:0] src_mac;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [31:0] query_ip;

  modport source (
    output valid, kind, frame_length, hw_type, ptype, hw_len, plen,
           operation, src_mac, src_ip, dst_ip, query_ip,
    input  ready
  );
  modport sink (
    input  valid, kind, frame_length, hw_type, ptype, hw_len, plen,
           operation, src_mac, src_ip, dst_ip, query_ip,
    output ready
  );
endinterface

FILE: rtl/arc_out_if.sv
interface arc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        reply_needed;
  logic [47:0] peer_mac;
  logic [31:0] peer_ip;
  logic        lookup_hit;
  logic        request_needed;
  logic        dad_conflict;

  modport source (
    output valid, status, reply_needed, peer_mac, peer_ip, lookup_hit,
           request_needed, dad_conflict,
    input  ready
  );
  modport sink (
    input  valid, status, reply_needed, peer_mac, peer_ip, lookup_hit,
           request_needed, dad_conflict,
    output ready
  );
endinterface

FILE: rtl/arc_cfg_if.sv
interface arc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [47:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/arp_receive_and_cache_core.sv
// Channel   Dir  Payload
// in_ch     in   ARP header, resolve or static add item
// out_ch    out  status, reply and lookup decision, DAD flag
// cfg_ch    in   register index (0 our_ip, 1 our_mac, 2 probe_ip) and data
//
// One item is in flight at a time. A resolve, an insert or a header for us
// walks the cached entries through a single memory read port, one entry per
// cycle, until a hit or the last entry; other items skip the walk.
// The result beat is held until taken; in_ch is ready again the cycle after.
// Reset empties the cache (count zero) and clears the registers and the flag.
`include "assert_macros.svh"

module arp_receive_and_cache_core (
  input logic   clk_i,
  input logic   rst_ni,
  arc_in_if.sink    in_ch,
  arc_out_if.source out_ch,
  arc_cfg_if.sink   cfg_ch
);
  import arc_pkg::*;

  arc_item_t   item;
  arc_result_t result;
  arc_cmd_t    cmd;
  arc_sts_t    sts;
  logic        in_ready, out_valid;

  assign item.kind         = in_ch.kind;
  assign item.frame_length = in_ch.frame_length;
  assign item.hw_type      = in_ch.hw_type;
  assign item.ptype        = in_ch.ptype;
  assign item.hw_len       = in_ch.hw_len;
  assign item.plen         = in_ch.plen;
  assign item.operation    = in_ch.operation;
  assign item.src_mac      = in_ch.src_mac;
  assign item.src_ip       = in_ch.src_ip;
  assign item.dst_ip       = in_ch.dst_ip;
  assign item.query_ip     = in_ch.query_ip;

  assign cfg_ch.ready = 1'b1;

  arc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  arc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .cfg_we_i    (cfg_ch.valid),
    .cfg_index_i (cfg_ch.index),
    .cfg_data_i  (cfg_ch.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .result_o    (result)
  );

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid;
  assign out_ch.status         = result.status;
  assign out_ch.reply_needed   = result.reply_needed;
  assign out_ch.peer_mac       = result.peer_mac;
  assign out_ch.peer_ip        = result.peer_ip;
  assign out_ch.lookup_hit     = result.lookup_hit;
  assign out_ch.request_needed = result.request_needed;
  assign out_ch.dad_conflict   = result.dad_conflict;

  `ASSERT_NEVER(a_one_in_flight, in_ready && out_valid, "input taken while result pending")
  `ASSERT_PROP(a_idle_after_beat, out_valid && out_ch.ready |=> in_ready, "not idle after result")
  `ASSERT_NEVER(a_hit_and_miss, out_valid && result.lookup_hit && result.request_needed, "hit and miss")
  `ASSERT_PROP(a_accept_runs, in_ch.valid && in_ready |=> !in_ready && !out_valid, "accept skipped work")

endmodule

FILE: rtl/arc_ctrl.sv
module arc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  arc_pkg::arc_sts_t sts_i,
  output arc_pkg::arc_cmd_t cmd_o
);
  import arc_pkg::*;

  arc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (!sts_i.need_search) begin
          state_d = ST_FINISH;
        end else if (sts_i.found || sts_i.scan_miss) begin
          state_d = sts_i.need_write ? ST_WRITE : ST_FINISH;
        end
      end
      ST_WRITE: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

FILE: rtl/arc_dp.sv
module arc_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  arc_pkg::arc_item_t           item_i,
  input  logic                         cfg_we_i,
  input  logic [arc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [arc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  arc_pkg::arc_cmd_t            cmd_i,
  output arc_pkg::arc_sts_t            sts_o,
  output arc_pkg::arc_result_t         result_o
);
  import arc_pkg::*;

  // Configuration and flags.
  logic [31:0] our_ip_q;
  logic [47:0] our_mac_q;
  logic [31:0] probe_ip_q;
  logic        conflict_q, conflict_d;

  // Item under work and the result register.
  arc_item_t   item_q;
  arc_result_t result_q;

  // Cache memory.
  logic [31:0] ip_mem  [CACHE_ENTRIES];
  logic [47:0] mac_mem [CACHE_ENTRIES];
  logic [31:0] rd_ip_q;
  logic [47:0] rd_mac_q;

  // Scan control.
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  scan_q;
  logic              rd_vld_q;
  logic [SLOT_W-1:0] rd_slot_q;
  logic              found_q;
  logic [SLOT_W-1:0] found_slot_q;
  logic [47:0]       found_mac_q;

  logic        is_arp, is_resolve, is_add;
  logic        hdr_ok, for_us, conflict_set, reply;
  logic [1:0]  status;
  logic [31:0] key_ip;
  logic        issue, hit_now, cache_full;
  logic [SLOT_W-1:0] wr_slot;

  always_comb begin
    is_arp     = (item_q.kind == KIND_ARP);
    is_resolve = (item_q.kind == KIND_RESOLVE);
    is_add     = (item_q.kind == KIND_ADD);

    if (!is_arp) begin
      status = STATUS_OK;
    end else if (item_q.frame_length < MIN_HDR_BYTES) begin
      status = STATUS_SHORT;
    end else if (item_q.hw_type != HW_ETHERNET || item_q.ptype != PROTO_IPV4 ||
                 item_q.hw_len != MAC_BYTES || item_q.plen != IP_BYTES) begin
      status = STATUS_BAD;
    end else begin
      status = STATUS_OK;
    end

    hdr_ok       = is_arp && (status == STATUS_OK);
    for_us       = hdr_ok && (item_q.dst_ip == our_ip_q);
    reply        = for_us && (item_q.operation == OP_REQUEST);
    conflict_set = hdr_ok && (probe_ip_q != 32'd0) &&
                   (item_q.src_ip == probe_ip_q) && (item_q.src_mac != our_mac_q);
    conflict_d   = conflict_q | conflict_set;
    key_ip       = is_arp ? item_q.src_ip : item_q.query_ip;

    sts_o.need_search = for_us || is_resolve || is_add;
    sts_o.need_write  = for_us || is_add;
    sts_o.found       = found_q;
    sts_o.scan_miss   = !found_q && !rd_vld_q && (scan_q == count_q);

    issue      = cmd_i.scan && !found_q && (scan_q < count_q);
    hit_now    = cmd_i.scan && rd_vld_q && (rd_ip_q == key_ip);
    cache_full = (count_q == CNT_W'(CACHE_ENTRIES));

    if (found_q) begin
      wr_slot = found_slot_q;
    end else if (cache_full) begin
      wr_slot = '0;
    end else begin
      wr_slot = count_q[SLOT_W-1:0];
    end
  end

  // The read port always follows the scan pointer; the read data is registered.
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      ip_mem[wr_slot]  <= key_ip;
      mac_mem[wr_slot] <= item_q.src_mac;
    end
    rd_ip_q  <= ip_mem[scan_q[SLOT_W-1:0]];
    rd_mac_q <= mac_mem[scan_q[SLOT_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
    if (!found_q && hit_now) begin
      found_slot_q <= rd_slot_q;
      found_mac_q  <= rd_mac_q;
    end
    if (issue) rd_slot_q <= scan_q[SLOT_W-1:0];
    if (cmd_i.finish) begin
      result_q.status         <= status;
      result_q.reply_needed   <= reply;
      result_q.peer_mac       <= reply ? item_q.src_mac :
                                 (is_resolve && found_q) ? found_mac_q : 48'd0;
      result_q.peer_ip        <= reply ? item_q.src_ip :
                                 is_resolve ? item_q.query_ip : 32'd0;
      result_q.lookup_hit     <= is_resolve && found_q;
      result_q.request_needed <= is_resolve && !found_q;
      result_q.dad_conflict   <= conflict_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      our_ip_q   <= '0;
      our_mac_q  <= '0;
      probe_ip_q <= '0;
      conflict_q <= 1'b0;
      count_q    <= '0;
      scan_q     <= '0;
      rd_vld_q   <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      // A write to probe_ip rearms the watch and drops the flag.
      if (cfg_we_i && (cfg_index_i == REG_PROBE_IP)) begin
        conflict_q <= 1'b0;
      end else if (cmd_i.finish) begin
        conflict_q <= conflict_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_OUR_IP:   our_ip_q <= cfg_data_i[31:0];
          REG_OUR_MAC:  our_mac_q <= cfg_data_i;
          REG_PROBE_IP: probe_ip_q <= cfg_data_i[31:0];
          default: ;
        endcase
      end

      if (cmd_i.load) begin
        scan_q   <= '0;
        rd_vld_q <= 1'b0;
        found_q  <= 1'b0;
      end else begin
        rd_vld_q <= issue;
        if (issue) scan_q <= scan_q + CNT_W'(1);
        if (hit_now) found_q <= 1'b1;
      end

      if (cmd_i.write && !found_q && !cache_full) count_q <= count_q + CNT_W'(1);
    end
  end

  assign result_o = result_q;

endmodule

FILE: test/arp_receive_and_cache_core_tb.sv
`timescale 1ns / 100ps

module arp_receive_and_cache_core_tb;
  import arc_pkg::*;

  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam logic [1:0]  REG_UNUSED  = 2'd3;
  localparam logic [15:0] OP_REPLY    = 16'd2;

  localparam logic [31:0] HOME_IP  = 32'hC0A8_0001;
  localparam logic [47:0] HOME_MAC = 48'h02_00_5E_10_20_30;
  localparam logic [31:0] PEER_IP  = 32'hC0A8_0010;
  localparam logic [31:0] DAD_IP   = 32'hC0A8_00FE;

  localparam int IP_POOL_SIZE     = 40;
  localparam int MAC_POOL_SIZE    = 8;
  localparam int PHASE_ITEMS      = 365;
  localparam int WATCHDOG_CYCLES  = 4000;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_e;

  logic clk_i;
  logic rst_ni;

  arc_in_if  in_ch ();
  arc_out_if out_ch ();
  arc_cfg_if cfg_ch ();

  arp_receive_and_cache_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predicted copy of the block's registers and cache.
  logic [31:0] our_ip_q;
  logic [47:0] our_mac_q;
  logic [31:0] probe_ip_q;
  logic [31:0] cached_ip  [CACHE_ENTRIES];
  logic [47:0] cached_mac [CACHE_ENTRIES];
  int          cached_count;
  logic        dad_flag;

  arc_result_t pending_decisions[$];
  int          failures;
  int          quiet_cycles;

  stall_mode_e stall_mode;
  int          stall_run;
  logic        stall_hold;
  bit          sender_bursty;
  int          burst_left;

  logic [31:0] ip_pool  [IP_POOL_SIZE];
  logic [47:0] mac_pool [MAC_POOL_SIZE];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  function automatic int cache_slot_of(logic [31:0] ip);
    for (int i = 0; i < cached_count; i++) begin
      if (cached_ip[i] == ip) return i;
    end
    return -1;
  endfunction

  function automatic void cache_store(logic [31:0] ip, logic [47:0] mac);
    int slot;
    slot = cache_slot_of(ip);
    if (slot < 0) begin
      // A new address goes to the next free slot; a full cache recycles slot 0.
      if (cached_count < CACHE_ENTRIES) begin
        slot = cached_count;
        cached_count++;
      end else begin
        slot = 0;
      end
      cached_ip[slot] = ip;
    end
    cached_mac[slot] = mac;
  endfunction

  function automatic arc_result_t decide_arp_item(arc_item_t it);
    arc_result_t r;
    int slot;
    r = '0;
    case (it.kind)
      KIND_ARP: begin
        if (it.frame_length < MIN_HDR_BYTES) begin
          r.status = STATUS_SHORT;
        end else if (it.hw_type != HW_ETHERNET || it.ptype != PROTO_IPV4 ||
                     it.hw_len != MAC_BYTES || it.plen != IP_BYTES) begin
          r.status = STATUS_BAD;
        end else begin
          r.status = STATUS_OK;
          if (probe_ip_q != '0 && it.src_ip == probe_ip_q &&
              it.src_mac != our_mac_q) begin
            dad_flag = 1'b1;
          end
          if (it.dst_ip == our_ip_q) begin
            cache_store(it.src_ip, it.src_mac);
            if (it.operation == OP_REQUEST) begin
              r.reply_needed = 1'b1;
              r.peer_mac = it.src_mac;
              r.peer_ip = it.src_ip;
            end
          end
        end
      end
      KIND_RESOLVE: begin
        slot = cache_slot_of(it.query_ip);
        r.peer_ip = it.query_ip;
        if (slot >= 0) begin
          r.lookup_hit = 1'b1;
          r.peer_mac = cached_mac[slot];
        end else begin
          r.request_needed = 1'b1;
        end
      end
      KIND_ADD: begin
        cache_store(it.query_ip, it.src_mac);
      end
      default: begin
      end
    endcase
    r.dad_conflict = dad_flag;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  function automatic logic [31:0] pick_ip();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return ip_pool[$urandom_range(0, IP_POOL_SIZE - 1)];
  endfunction

  function automatic logic [47:0] pick_mac();
    if ($urandom_range(0, 1) == 0) return rand48();
    return mac_pool[$urandom_range(0, MAC_POOL_SIZE - 1)];
  endfunction

  function automatic arc_item_t arp_header(logic [15:0] op, logic [47:0] smac,
                                           logic [31:0] sip, logic [31:0] tip);
    arc_item_t it;
    it.kind = KIND_ARP;
    it.frame_length = ($urandom_range(0, 7) == 0) ? MIN_HDR_BYTES :
                      11'($urandom_range(28, 2047));
    it.hw_type = HW_ETHERNET;
    it.ptype = PROTO_IPV4;
    it.hw_len = MAC_BYTES;
    it.plen = IP_BYTES;
    it.operation = op;
    it.src_mac = smac;
    it.src_ip = sip;
    it.dst_ip = tip;
    it.query_ip = $urandom();
    return it;
  endfunction

  function automatic arc_item_t cache_item(logic [1:0] kind, logic [31:0] ip,
                                           logic [47:0] mac);
    arc_item_t it;
    it = arp_header(OP_REQUEST, mac, $urandom(), $urandom());
    it.kind = kind;
    it.query_ip = ip;
    return it;
  endfunction

  function automatic arc_item_t random_arp_item();
    arc_item_t it;
    logic [15:0] op;
    int pick;
    case ($urandom_range(0, 9))
      0: op = 16'($urandom());
      1, 2: op = OP_REPLY;
      default: op = OP_REQUEST;
    endcase
    it = arp_header(op, ($urandom_range(0, 4) == 0) ? our_mac_q : pick_mac(), pick_ip(),
                    ($urandom_range(0, 3) == 0) ? pick_ip() : our_ip_q);
    it.query_ip = pick_ip();
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.kind = KIND_ARP;
    end else if (pick < 65) begin
      it.kind = KIND_RESOLVE;
    end else if (pick < 78) begin
      it.kind = KIND_ADD;
    end else if (pick < 88) begin
      // Well-formed header with one field broken.
      case ($urandom_range(0, 4))
        0: it.frame_length = 11'($urandom_range(0, 27));
        1: it.hw_type = 16'($urandom());
        2: it.ptype = 16'($urandom());
        3: it.hw_len = 8'($urandom());
        default: it.plen = 8'($urandom());
      endcase
    end else begin
      it.kind = 2'($urandom());
      it.frame_length = 11'($urandom());
      it.hw_type = 16'($urandom());
      it.ptype = 16'($urandom());
      it.hw_len = 8'($urandom());
      it.plen = 8'($urandom());
      it.operation = 16'($urandom());
      it.src_mac = rand48();
      it.src_ip = $urandom();
      it.dst_ip = $urandom();
      it.query_ip = $urandom();
    end
    return it;
  endfunction

  task automatic drive_item(arc_item_t it);
    in_ch.kind <= it.kind;
    in_ch.frame_length <= it.frame_length;
    in_ch.hw_type <= it.hw_type;
    in_ch.ptype <= it.ptype;
    in_ch.hw_len <= it.hw_len;
    in_ch.plen <= it.plen;
    in_ch.operation <= it.operation;
    in_ch.src_mac <= it.src_mac;
    in_ch.src_ip <= it.src_ip;
    in_ch.dst_ip <= it.dst_ip;
    in_ch.query_ip <= it.query_ip;
  endtask

  // Valid stays high after the beat so that a back-to-back item needs no toggle.
  task automatic send_item(arc_item_t it);
    int gap;
    if (sender_bursty && burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 45) : $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    drive_item(it);
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    pending_decisions.push_back(decide_arp_item(it));
  endtask

  task automatic wait_decisions_drained();
    in_ch.valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    case (idx)
      REG_OUR_IP: our_ip_q = value[31:0];
      REG_OUR_MAC: our_mac_q = value;
      REG_PROBE_IP: begin
        probe_ip_q = value[31:0];
        dad_flag = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  // The upper data bits of the address registers carry noise that must be dropped.
  task automatic set_registers(logic [31:0] ip, logic [47:0] mac, logic [31:0] probe);
    logic [47:0] noise;
    noise = rand48();
    wait_decisions_drained();
    write_reg(REG_OUR_IP, {noise[47:32], ip});
    write_reg(REG_OUR_MAC, mac);
    write_reg(REG_PROBE_IP, {noise[31:16], probe});
    write_reg(REG_UNUSED, rand48());
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_header_checks();
    arc_item_t it;
    // The cache is empty after reset, so this resolve has to miss.
    send_item(cache_item(KIND_RESOLVE, HOME_IP, '0));
    set_registers(HOME_IP, HOME_MAC, '0);
    it = arp_header(OP_REQUEST, rand48(), PEER_IP, HOME_IP);
    it.frame_length = '0;
    send_item(it);
    it.frame_length = MIN_HDR_BYTES - 11'd1;
    send_item(it);
    it.frame_length = '1;
    it.src_mac = '1;
    send_item(it);
    it.frame_length = MIN_HDR_BYTES;
    it.hw_type = '1;
    send_item(it);
    it.hw_type = HW_ETHERNET;
    it.ptype = 16'h86DD;
    send_item(it);
    it.ptype = PROTO_IPV4;
    it.hw_len = '0;
    send_item(it);
    it.hw_len = MAC_BYTES;
    it.plen = '1;
    send_item(it);
    it.plen = IP_BYTES;
    it.operation = OP_REPLY;
    it.src_ip = '1;
    send_item(it);
    it.operation = '1;
    it.src_ip = '0;
    send_item(it);
    it.operation = OP_REQUEST;
    it.dst_ip = HOME_IP ^ 32'h1;
    send_item(it);
    it = '1;
    send_item(it);
  endtask

  task automatic test_cache_ops();
    send_item(cache_item(KIND_RESOLVE, PEER_IP, '0));
    send_item(cache_item(KIND_RESOLVE, '0, '0));
    send_item(cache_item(KIND_RESOLVE, 32'h0A00_0001, '0));
    send_item(cache_item(KIND_ADD, 32'h0A00_0001, '0));
    send_item(cache_item(KIND_RESOLVE, 32'h0A00_0001, '1));
    send_item(cache_item(KIND_ADD, 32'h0A00_0001, '1));
    send_item(cache_item(KIND_RESOLVE, 32'h0A00_0001, '0));
  endtask

  task automatic test_duplicate_address();
    arc_item_t it;
    set_registers(HOME_IP, HOME_MAC, DAD_IP);
    // Our own MAC on the probed address is not a conflict.
    it = arp_header(OP_REQUEST, HOME_MAC, DAD_IP, HOME_IP ^ 32'h100);
    send_item(it);
    it.src_mac = HOME_MAC ^ 48'h1;
    it.hw_len = 8'd5;
    send_item(it);
    it.hw_len = MAC_BYTES;
    it.frame_length = 11'd20;
    send_item(it);
    it.frame_length = MIN_HDR_BYTES;
    send_item(it);
    send_item(cache_item(KIND_RESOLVE, DAD_IP, '0));
    set_registers(HOME_IP, HOME_MAC, '0);
    it.src_ip = '0;
    send_item(it);
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < IP_POOL_SIZE; i++) ip_pool[i] = $urandom();
    ip_pool[6] = '0;
    ip_pool[7] = '1;
    for (int i = 0; i < MAC_POOL_SIZE; i++) mac_pool[i] = rand48();
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: set_registers('0, '0, '0);
        1: set_registers('1, '1, ip_pool[3]);
        2: set_registers(ip_pool[0], rand48(), ip_pool[5]);
        3: set_registers(ip_pool[1], mac_pool[0], '1);
        default: set_registers(ip_pool[2], mac_pool[1], ip_pool[4]);
      endcase
      // The first phase starts with neither side idling.
      stall_mode = stall_mode_e'(p % 3);
      sender_bursty = (p != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) begin
          wait_decisions_drained();
          stall_mode = stall_mode_e'((p + 1) % 3);
          sender_bursty = !sender_bursty;
        end
        send_item(random_arp_item());
      end
    end
  endtask

  // Receiver back-pressure: always ready, random stalls, or runs of each.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      case (stall_mode)
        STALL_NONE: out_ch.ready <= 1'b1;
        STALL_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (stall_run == 0) begin
            stall_hold = !stall_hold;
            stall_run = $urandom_range(1, 16);
          end
          stall_run--;
          out_ch.ready <= stall_hold;
        end
      endcase
    end
  end

  always @(posedge clk_i) begin : check_results
    arc_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_decisions.size() == 0) begin
        $error("result beat arrived with no decision pending");
        failures++;
      end else begin
        want = pending_decisions.pop_front();
        check_field("status", 64'(want.status), 64'(out_ch.status));
        check_field("reply_needed", 64'(want.reply_needed), 64'(out_ch.reply_needed));
        check_field("peer_mac", 64'(want.peer_mac), 64'(out_ch.peer_mac));
        check_field("peer_ip", 64'(want.peer_ip), 64'(out_ch.peer_ip));
        check_field("lookup_hit", 64'(want.lookup_hit), 64'(out_ch.lookup_hit));
        check_field("request_needed", 64'(want.request_needed),
                    64'(out_ch.request_needed));
        check_field("dad_conflict", 64'(want.dad_conflict), 64'(out_ch.dad_conflict));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_CYCLES) begin
      $display("FAIL arp_receive_and_cache_core");
      $finish;
    end
  end

  initial begin
    failures = 0;
    quiet_cycles = 0;
    stall_mode = STALL_RANDOM;
    stall_run = 0;
    stall_hold = 1'b0;
    sender_bursty = 1'b1;
    burst_left = 0;
    our_ip_q = '0;
    our_mac_q = '0;
    probe_ip_q = '0;
    cached_count = 0;
    dad_flag = 1'b0;
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    drive_item('0);
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_header_checks();
    test_cache_ops();
    test_duplicate_address();
    test_random_traffic();

    wait_decisions_drained();
    repeat (CACHE_ENTRIES + 8) @(posedge clk_i);
    if (failures == 0 && pending_decisions.size() == 0) begin
      $display("PASS arp_receive_and_cache_core");
    end else begin
      $display("FAIL arp_receive_and_cache_core");
    end
    $finish;
  end

endmodule
